@@ hw/rtl/trf_pkg.sv @@
`default_nettype none

package trf_pkg;

  // frame limits
  localparam int MAX_PAYLOAD  = 256;
  localparam int LEN_W        = $clog2(MAX_PAYLOAD + 1);
  localparam int FLEN_W       = 16;
  localparam int LEN_OVERHEAD = 14;

  // channel field widths
  localparam int BYTE_W       = 8;
  localparam int PLEN_W       = 9;

  // configuration port
  localparam int APB_ADDR_W   = 4;
  localparam int APB_DATA_W   = 64;
  localparam logic REG_DEST_ADDRESS = 1'b0;

  // frame constants
  localparam logic [BYTE_W-1:0] START_DELIM = 8'h7E;
  localparam logic [BYTE_W-1:0] TYPE_TX_REQ = 8'h10;
  localparam logic [BYTE_W-1:0] NET16_HI    = 8'hFF;
  localparam logic [BYTE_W-1:0] NET16_LO    = 8'hFE;
  localparam logic [BYTE_W-1:0] RADIUS      = 8'h00;
  localparam logic [BYTE_W-1:0] OPTIONS     = 8'h00;
  localparam logic [BYTE_W-1:0] CSUM_BASE   = 8'hFF;

  // header byte positions
  localparam int HDR_IDX_W = 5;
  localparam logic [HDR_IDX_W-1:0] HDR_START      = 5'd0;
  localparam logic [HDR_IDX_W-1:0] HDR_LEN_HI     = 5'd1;
  localparam logic [HDR_IDX_W-1:0] HDR_LEN_LO     = 5'd2;
  localparam logic [HDR_IDX_W-1:0] HDR_TYPE       = 5'd3;
  localparam logic [HDR_IDX_W-1:0] HDR_FRAME_ID   = 5'd4;
  localparam logic [HDR_IDX_W-1:0] HDR_DEST_FIRST = 5'd5;
  localparam logic [HDR_IDX_W-1:0] HDR_DEST_LAST  = 5'd12;
  localparam logic [HDR_IDX_W-1:0] HDR_NET_HI     = 5'd13;
  localparam logic [HDR_IDX_W-1:0] HDR_NET_LO     = 5'd14;
  localparam logic [HDR_IDX_W-1:0] HDR_RADIUS     = 5'd15;
  localparam logic [HDR_IDX_W-1:0] HDR_OPTIONS    = 5'd16;
  localparam logic [HDR_IDX_W-1:0] HDR_DONE       = 5'd17;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              first;
    logic              last;
    logic [FLEN_W-1:0] flen;
  } queue_entry_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } queue_status_t;

  typedef enum logic {
    BK_DATA,
    BK_CHECKSUM
  } back_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/trf_if.sv @@
`default_nettype none

// payload byte channel into the framer
interface trf_in_if;
  logic                         valid;
  logic                         ready;
  logic [trf_pkg::BYTE_W-1:0]   payload_byte;
  logic [trf_pkg::PLEN_W-1:0]   payload_length;

  modport source (output valid, output payload_byte, output payload_length, input ready);
  modport sink   (input valid, input payload_byte, input payload_length, output ready);
endinterface

// frame byte channel out of the framer
interface trf_out_if;
  logic                         valid;
  logic                         ready;
  logic [trf_pkg::BYTE_W-1:0]   frame_byte;
  logic                         frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/trf_front.sv @@
`default_nettype none

module trf_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  trf_in_if.sink                      req,
  input  trf_pkg::queue_status_t      q_status,
  output logic                        push,
  output trf_pkg::queue_entry_t       push_entry
);
  import trf_pkg::*;

  logic [LEN_W-1:0] bytes_left;
  logic [LEN_W-1:0] bytes_left_next;
  logic [LEN_W-1:0] len_clamped;
  logic             first;

  assign req.ready = !q_status.full;
  assign push      = req.valid && req.ready;
  assign first     = (bytes_left == '0);

  // length clamp: zero counts as one, oversize limited
  always_comb begin
    if (req.payload_length == '0) begin
      len_clamped = LEN_W'(1);
    end else if (32'(req.payload_length) > MAX_PAYLOAD) begin
      len_clamped = LEN_W'(MAX_PAYLOAD);
    end else begin
      len_clamped = LEN_W'(req.payload_length);
    end
  end

  // classify the byte and count down the frame
  always_comb begin
    bytes_left_next  = (first ? len_clamped : bytes_left) - LEN_W'(1);
    push_entry.data  = req.payload_byte;
    push_entry.first = first;
    push_entry.last  = (bytes_left_next == '0);
    push_entry.flen  = FLEN_W'(len_clamped) + FLEN_W'(LEN_OVERHEAD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= '0;
    end else if (push) begin
      bytes_left <= bytes_left_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/trf_queue.sv @@
`default_nettype none

module trf_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  trf_pkg::queue_entry_t       push_entry,
  input  wire logic                   pop,
  output trf_pkg::queue_entry_t       head,
  output trf_pkg::queue_status_t      status
);
  import trf_pkg::*;

  queue_entry_t      entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head         = entries[rd_ptr];
  assign status.count = count;
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/trf_back.sv @@
`default_nettype none

module trf_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [trf_pkg::APB_DATA_W-1:0] dest_address,
  input  trf_pkg::queue_entry_t              head,
  input  trf_pkg::queue_status_t             q_status,
  output logic                               pop,
  trf_out_if.source                          frame
);
  import trf_pkg::*;

  back_state_t          state;
  back_state_t          state_next;
  logic [HDR_IDX_W-1:0] hdr_idx;
  logic [HDR_IDX_W-1:0] hdr_idx_next;
  logic [BYTE_W-1:0]    running_sum;
  logic [BYTE_W-1:0]    running_sum_next;
  logic [BYTE_W-1:0]    frame_counter;
  logic [BYTE_W-1:0]    frame_counter_next;
  logic                 out_valid;
  logic [BYTE_W-1:0]    out_byte;
  logic                 out_end;
  logic                 load;
  logic                 emit;
  logic [BYTE_W-1:0]    emit_byte;
  logic                 emit_end;
  logic [BYTE_W-1:0]    hdr_byte;
  logic [2:0]           dest_sel;

  assign frame.valid      = out_valid;
  assign frame.frame_byte = out_byte;
  assign frame.frame_end  = out_end;
  assign load             = !out_valid || frame.ready;
  assign dest_sel         = 3'(hdr_idx - HDR_DEST_FIRST);

  // header byte at the current position
  always_comb begin
    if (hdr_idx >= HDR_DEST_FIRST && hdr_idx <= HDR_DEST_LAST) begin
      hdr_byte = dest_address[{~dest_sel, 3'b000} +: BYTE_W];
    end else begin
      case (hdr_idx)
        HDR_START:    hdr_byte = START_DELIM;
        HDR_LEN_HI:   hdr_byte = head.flen[FLEN_W-1 -: BYTE_W];
        HDR_LEN_LO:   hdr_byte = head.flen[BYTE_W-1:0];
        HDR_TYPE:     hdr_byte = TYPE_TX_REQ;
        HDR_FRAME_ID: hdr_byte = frame_counter;
        HDR_NET_HI:   hdr_byte = NET16_HI;
        HDR_NET_LO:   hdr_byte = NET16_LO;
        HDR_RADIUS:   hdr_byte = RADIUS;
        HDR_OPTIONS:  hdr_byte = OPTIONS;
        default:      hdr_byte = '0;
      endcase
    end
  end

  // byte sequencer: header, payload, checksum
  always_comb begin
    state_next         = state;
    hdr_idx_next       = hdr_idx;
    running_sum_next   = running_sum;
    frame_counter_next = frame_counter;
    pop                = 1'b0;
    emit               = 1'b0;
    emit_byte          = head.data;
    emit_end           = 1'b0;
    case (state)
      BK_DATA: begin
        if (!q_status.empty && load) begin
          emit = 1'b1;
          if (head.first && hdr_idx != HDR_DONE) begin
            emit_byte    = hdr_byte;
            hdr_idx_next = hdr_idx + HDR_IDX_W'(1);
            if (hdr_idx == HDR_START) begin
              running_sum_next = '0;
            end else if (hdr_idx >= HDR_TYPE) begin
              running_sum_next = running_sum + hdr_byte;
            end
            if (hdr_idx == HDR_FRAME_ID) begin
              frame_counter_next = frame_counter + BYTE_W'(1);
            end
          end else begin
            emit_byte        = head.data;
            running_sum_next = running_sum + head.data;
            hdr_idx_next     = HDR_START;
            pop              = 1'b1;
            if (head.last) begin
              state_next = BK_CHECKSUM;
            end
          end
        end
      end
      BK_CHECKSUM: begin
        if (load) begin
          emit       = 1'b1;
          emit_byte  = CSUM_BASE - running_sum;
          emit_end   = 1'b1;
          state_next = BK_DATA;
        end
      end
      default: begin
        state_next = BK_DATA;
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_DATA;
      hdr_idx       <= HDR_START;
      running_sum   <= '0;
      frame_counter <= '0;
    end else begin
      state         <= state_next;
      hdr_idx       <= hdr_idx_next;
      running_sum   <= running_sum_next;
      frame_counter <= frame_counter_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (load && emit) begin
      out_byte <= emit_byte;
      out_end  <= emit_end;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/transmit_request_framer.sv @@
// Transmit-request framer: wraps payload bytes into radio API transmit-request
// frames. Each transfer on req carries one payload byte; payload_length is taken
// on the first byte of a frame (zero counts as one, values above 256 are
// clamped). The frame channel gives the 17 header bytes ahead of the first
// payload byte, then each payload byte, then the checksum with frame_end set.
// The frame channel moves one byte per cycle while the receiver is ready and the
// sequencer has a byte, through the single byte-wide output register. The input
// side takes a byte every cycle while the two-entry queue in front of the byte
// sequencer has room, so it can stall while a header or checksum goes out.
// dest_address (64 bits, APB address 0) is sampled as the header goes out and
// should be written only between frames. No clearing pass after reset.
`default_nettype none

module transmit_request_framer (
  input  wire logic                               clk,
  input  wire logic                               rst,
  trf_in_if.sink                                  req,
  trf_out_if.source                               frame,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [trf_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [trf_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [trf_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                    pready
);
  import trf_pkg::*;

  logic [APB_DATA_W-1:0] dest_address;
  logic                  reg_sel;
  logic                  push;
  logic                  pop;
  queue_entry_t          push_entry;
  queue_entry_t          head;
  queue_status_t         q_status;

  // configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_ADDR_W-1] == REG_DEST_ADDRESS);
  assign prdata  = reg_sel ? dest_address : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_address <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      dest_address <= pwdata;
    end
  end

  // accept and classify payload bytes
  trf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  // decoupling queue
  trf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // header, payload and checksum sequencer
  trf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .dest_address (dest_address),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .frame        (frame)
  );

  // queue never overfills
  assert property (@(posedge clk) disable iff (rst)
    q_status.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // a full queue holds off the input
  assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> !req.ready)
    else $error("input ready while queue full");

  // nothing is popped from an empty queue
  assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

  // a checksum transfer is never followed at once by another frame end
  assert property (@(posedge clk) disable iff (rst)
    (frame.valid && frame.ready && frame.frame_end) |=> !(frame.valid && frame.frame_end))
    else $error("two frame ends in a row");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import trf_pkg::*;

  // register map: one 64-bit register, so registers sit 8 bytes apart
  localparam logic [APB_ADDR_W-1:0] ADDR_DEST   = APB_ADDR_W'(8 * REG_DEST_ADDRESS);
  localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED = APB_ADDR_W'(8 * (REG_DEST_ADDRESS + 1));

  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 6;
  localparam int PHASE_FRAMES = 2;
  localparam int MAX_SHOWN    = 20;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic              frame_end;
  } frame_out_t;

  // one directed transfer, with an optional register write ahead of it
  typedef struct packed {
    logic                  cfg_wr;
    logic [APB_ADDR_W-1:0] cfg_addr;
    logic [APB_DATA_W-1:0] cfg_data;
    logic [BYTE_W-1:0]     pbyte;
    logic [PLEN_W-1:0]     plen;
    logic                  has_sum;
    logic [BYTE_W-1:0]     end_sum;
  } dir_row_t;

  localparam int DIR_N = 14;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // zero length right after reset: address 0, frame id 0
    '{1'b0, ADDR_DEST,   64'h0,                     8'h00, 9'd0,   1'b1, 8'hF2},
    // all-ones address, frame id 1
    '{1'b1, ADDR_DEST,   64'hFFFF_FFFF_FFFF_FFFF,   8'hFF, 9'd1,   1'b1, 8'hFA},
    // length on a later byte must be ignored
    '{1'b0, ADDR_DEST,   64'h0,                     8'h55, 9'd2,   1'b0, 8'h00},
    '{1'b0, ADDR_DEST,   64'h0,                     8'hAA, 9'd511, 1'b0, 8'h00},
    // write to a register that does not exist
    '{1'b1, ADDR_UNUSED, 64'h1234_5678_9ABC_DEF0,   8'h01, 9'd4,   1'b0, 8'h00},
    '{1'b0, ADDR_DEST,   64'h0,                     8'h02, 9'd0,   1'b0, 8'h00},
    '{1'b0, ADDR_DEST,   64'h0,                     8'h04, 9'd256, 1'b0, 8'h00},
    '{1'b0, ADDR_DEST,   64'h0,                     8'h08, 9'd3,   1'b0, 8'h00},
    // byte order of the address
    '{1'b1, ADDR_DEST,   64'h0123_4567_89AB_CDEF,   8'h10, 9'd3,   1'b0, 8'h00},
    '{1'b0, ADDR_DEST,   64'h0,                     8'h20, 9'd0,   1'b0, 8'h00},
    '{1'b0, ADDR_DEST,   64'h0,                     8'h40, 9'd255, 1'b0, 8'h00},
    '{1'b1, ADDR_DEST,   64'h8000_0000_0000_0001,   8'h7F, 9'd1,   1'b0, 8'h00},
    '{1'b1, ADDR_DEST,   64'h0,                     8'h80, 9'd2,   1'b0, 8'h00},
    '{1'b0, ADDR_DEST,   64'h0,                     8'hFE, 9'd128, 1'b0, 8'h00}
  };

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  trf_in_if  req_ch ();
  trf_out_if frame_ch ();

  transmit_request_framer dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .frame   (frame_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // frame state as the testbench tracks it
  logic [BYTE_W-1:0]     fr_id;
  logic [BYTE_W-1:0]     fr_sum;
  logic [PLEN_W-1:0]     fr_left;
  logic [APB_DATA_W-1:0] fr_dest;

  frame_out_t pending_frame_bytes [$];

  int  mismatches;
  int  bytes_sent;
  int  frames_started;
  int  bytes_checked;
  int  frames_checked;
  bit  bubbles_on;
  bit  hold_off_req;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < MAX_SHOWN)
      $display("%0t: %s: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic due_plain(input logic [BYTE_W-1:0] b, input logic last);
    frame_out_t e;
    e.frame_byte = b;
    e.frame_end  = last;
    pending_frame_bytes.push_back(e);
  endtask

  task automatic due_summed(input logic [BYTE_W-1:0] b);
    fr_sum = fr_sum + b;
    due_plain(b, 1'b0);
  endtask

  // frame bytes caused by one accepted payload byte
  task automatic build_frame_bytes(input logic [BYTE_W-1:0] b, input logic [PLEN_W-1:0] l);
    int               eff;
    logic [FLEN_W-1:0] flen;
    if (fr_left == '0) begin
      eff = (l == '0) ? 1 : ((l > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(l));
      flen = FLEN_W'(eff + LEN_OVERHEAD);
      fr_left = PLEN_W'(eff);
      fr_sum = '0;
      due_plain(START_DELIM, 1'b0);
      due_plain(flen[15:8], 1'b0);
      due_plain(flen[7:0], 1'b0);
      due_summed(TYPE_TX_REQ);
      due_summed(fr_id);
      fr_id = fr_id + 1'b1;
      for (int k = 0; k < 8; k++)
        due_summed(fr_dest[63 - 8 * k -: 8]);
      due_summed(NET16_HI);
      due_summed(NET16_LO);
      due_summed(RADIUS);
      due_summed(OPTIONS);
      frames_started++;
    end
    due_summed(b);
    fr_left = fr_left - 1'b1;
    if (fr_left == '0)
      due_plain(CSUM_BASE - fr_sum, 1'b1);
  endtask

  // offer one payload byte and wait for its transfer
  task automatic send_payload(input logic [BYTE_W-1:0] b, input logic [PLEN_W-1:0] l,
                              input logic has_sum, input logic [BYTE_W-1:0] sum);
    if (bubbles_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.payload_byte   <= b;
    req_ch.payload_length <= l;
    do @(posedge clk); while (!req_ch.ready);
    build_frame_bytes(b, l);
    if (has_sum)
      pending_frame_bytes[$].frame_byte = sum;
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [PLEN_W-1:0] len_field);
    int n;
    n = (len_field == '0) ? 1 : ((len_field > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(len_field));
    for (int i = 0; i < n; i++)
      send_payload(BYTE_W'($urandom_range(0, 255)),
                   (i == 0) ? len_field : PLEN_W'($urandom_range(0, 511)), 1'b0, '0);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_frame_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] a, input logic [APB_DATA_W-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [APB_ADDR_W-1:0] a, output logic [APB_DATA_W-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= a;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    d = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic report_mismatch_if(input logic [63:0] got, input logic [63:0] want);
    if (got !== want)
      report_mismatch("dest_address readback", got, want);
  endtask

  // register write between frames, then read back the address
  task automatic load_dest(input logic [APB_ADDR_W-1:0] a, input logic [APB_DATA_W-1:0] d);
    logic [APB_DATA_W-1:0] rd;
    wait_drained();
    apb_write(a, d);
    if (a == ADDR_DEST)
      fr_dest = d;
    apb_read(ADDR_DEST, rd);
    report_mismatch_if(rd, fr_dest);
  endtask

  // frame channel: compare each transfer with the oldest expected byte
  always @(posedge clk) begin
    frame_out_t e;
    if (!rst && frame_ch.valid && frame_ch.ready) begin
      if (pending_frame_bytes.size() == 0) begin
        report_mismatch("frame byte with none expected", 64'(frame_ch.frame_byte), '0);
      end else begin
        e = pending_frame_bytes.pop_front();
        if (frame_ch.frame_byte !== e.frame_byte)
          report_mismatch("frame_byte", 64'(frame_ch.frame_byte), 64'(e.frame_byte));
        if (frame_ch.frame_end !== e.frame_end)
          report_mismatch("frame_end", 64'(frame_ch.frame_end), 64'(e.frame_end));
      end
      bytes_checked++;
      if (frame_ch.frame_end === 1'b1)
        frames_checked++;
    end
  end

  // frame receiver: random stalls, one long hold-off on request
  initial begin
    frame_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        frame_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (bubbles_on && $urandom_range(0, 3) == 0) begin
        frame_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      frame_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // stimulus
  initial begin
    dir_row_t              row;
    logic [APB_DATA_W-1:0] d;
    int                    r;
    logic [PLEN_W-1:0]     len;
    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    req_ch.valid          = 1'b0;
    req_ch.payload_byte   = '0;
    req_ch.payload_length = '0;
    fr_id                 = '0;
    fr_sum                = '0;
    fr_left               = '0;
    fr_dest               = '0;
    mismatches            = 0;
    bytes_sent            = 0;
    frames_started        = 0;
    bytes_checked         = 0;
    frames_checked        = 0;
    bubbles_on            = 1'b1;
    hold_off_req          = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < DIR_N; i++) begin
      row = DIR_ROWS[i];
      if (row.cfg_wr)
        load_dest(row.cfg_addr, row.cfg_data);
      send_payload(row.pbyte, row.plen, row.has_sum, row.end_sum);
    end

    // random frames, a new address each phase; last phase runs without gaps
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1:       d = '0;
        3:       d = '1;
        default: d = {$urandom, $urandom};
      endcase
      load_dest(ADDR_DEST, d);
      if (p == PHASES - 1)
        bubbles_on = 1'b0;
      if (p == 0) begin
        // oversized length, output held off so the input backs up
        hold_off_req = 1'b1;
        send_frame(PLEN_W'($urandom_range(MAX_PAYLOAD + 1, 511)));
      end
      for (int f = 0; f < PHASE_FRAMES; f++) begin
        r = $urandom_range(0, 99);
        if (r < 85)
          len = PLEN_W'($urandom_range(0, 1));
        else if (r < 97)
          len = PLEN_W'($urandom_range(2, 4));
        else
          len = PLEN_W'($urandom_range(5, 12));
        send_frame(len);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);

    $display("sent %0d payload bytes in %0d frames, checked %0d frame bytes, %0d frame ends",
             bytes_sent, frames_started, bytes_checked, frames_checked);
    $display("one clamped frame ran under a %0d-cycle output hold-off", HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/trf_pkg.sv
hw/rtl/trf_if.sv
hw/rtl/trf_front.sv
hw/rtl/trf_queue.sv
hw/rtl/trf_back.sv
hw/rtl/transmit_request_framer.sv
tb/sv/tb_top.sv
